// ===== hdl/plfg_pkg.sv =====
// ----------------------------------------------------------------------------
// plfg_pkg: shared types and constants of the linear PWM fade block
// Level and time widths, item mode codes, register indexes, state types.
// ----------------------------------------------------------------------------
`default_nettype none

package plfg_pkg;

	localparam int LEVEL_BITS = 8;
	localparam int TIME_BITS  = 16;
	localparam int PROD_BITS  = LEVEL_BITS + TIME_BITS;
	localparam int CNT_BITS   = $clog2(PROD_BITS);

	localparam int GAMMA_DEPTH   = 256;
	localparam int GAMMA_AW      = $clog2(GAMMA_DEPTH);
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	localparam logic [CFG_IDX_BITS-1:0] REG_FADE_TIME = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAMMA_EN  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ATTACHED  = 2'd2;

	typedef enum logic [1:0] {
		MODE_SET   = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_GAMMA = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_MAP,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_phase_t;

	typedef struct packed {
		logic                  start;
		logic [LEVEL_BITS-1:0] mag;
		logic [TIME_BITS-1:0]  mult;
		logic [TIME_BITS-1:0]  divisor;
	} md_req_t;

endpackage

`default_nettype wire

// ===== hdl/pwm_linear_fade_with_gamma.sv =====
// ----------------------------------------------------------------------------
// pwm_linear_fade_with_gamma: linear PWM fade with gamma lookup
// Applies or fades toward brightness targets on millisecond ticks and drives
// an optionally gamma-mapped duty value.
// ----------------------------------------------------------------------------
// One item is in work at a time and every item gives exactly one result. A
// set-target, table-write or idle tick item goes from acceptance straight to
// the done state, and a set or tick that drives a duty without interpolation
// first passes the map state for the registered gamma table read. A tick that
// interpolates a fade runs the serial unit, which does the multiply (one bit
// of the tick count per cycle) and then the divide (one quotient bit per
// cycle); the quotient is then taken up and, when the level moves, the gamma
// table is read. The done state waits until the output register is free, and
// the next item can be accepted as soon as the result goes valid.
// A new item is taken while the previous result still waits at the output
// register. The gamma table resets to all zero through per-entry valid bits,
// so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_linear_fade_with_gamma (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [plfg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [plfg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [1:0]                          mode,
	input  wire  [7:0]                          level_value,
	input  wire  [7:0]                          table_index,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                duty_write,
	output logic [7:0]                          duty,
	output logic [7:0]                          current_level,
	output logic [7:0]                          target_level
);

	plfg_pkg::state_t                     state_q;
	plfg_pkg::state_t                     state_nxt;
	plfg_pkg::mode_t                      mode_in;

	logic [plfg_pkg::TIME_BITS-1:0]       fade_q;
	logic                                 gam_en_q;
	logic                                 attached_q;

	logic [plfg_pkg::LEVEL_BITS-1:0]      now_q;
	logic [plfg_pkg::LEVEL_BITS-1:0]      goal_q;
	logic [plfg_pkg::LEVEL_BITS-1:0]      origin_q;
	logic [plfg_pkg::TIME_BITS-1:0]       ticks_q;
	logic                                 wrote_q;
	logic [plfg_pkg::LEVEL_BITS-1:0]      duty_src_q;

	logic [7:0]                           gamma_mem [plfg_pkg::GAMMA_DEPTH];
	logic [plfg_pkg::GAMMA_DEPTH-1:0]     gvalid_q;
	logic [7:0]                           grd_q;
	logic                                 grd_valid_q;

	logic                                 out_valid_q;
	logic                                 out_write_q;
	logic [7:0]                           out_duty_q;
	logic [7:0]                           out_cur_q;
	logic [7:0]                           out_tgt_q;

	logic                                 acc_in;
	logic                                 out_free;
	logic [plfg_pkg::TIME_BITS-1:0]       tick_next;
	logic                                 immediate;
	logic                                 fading;
	logic                                 reached;
	logic                                 neg;
	plfg_pkg::md_req_t                    md_req;
	logic                                 md_done;
	logic [plfg_pkg::LEVEL_BITS-1:0]      md_quot;
	logic [plfg_pkg::LEVEL_BITS-1:0]      md_next;
	logic [7:0]                           mapped;

	assign mode_in   = plfg_pkg::mode_t'(mode);
	assign in_ready  = state_q == plfg_pkg::S_IDLE;
	assign acc_in    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign tick_next = (ticks_q == plfg_pkg::TIME_MAX) ? ticks_q : ticks_q + 1'b1;
	assign immediate = fade_q == '0 || !attached_q;
	assign fading    = fade_q != '0 && attached_q && now_q != goal_q;
	assign reached   = tick_next >= fade_q;
	assign neg       = goal_q < origin_q;

	assign md_req.start   = acc_in && mode_in == plfg_pkg::MODE_TICK && fading && !reached;
	assign md_req.mag     = neg ? origin_q - goal_q : goal_q - origin_q;
	assign md_req.mult    = tick_next;
	assign md_req.divisor = fade_q;

	assign md_next = neg ? origin_q - md_quot : origin_q + md_quot;
	assign mapped  = gam_en_q ? (grd_valid_q ? grd_q : 8'd0) : duty_src_q;

	plfg_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.done   (md_done),
		.quot   (md_quot)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			plfg_pkg::S_IDLE: begin
				if (acc_in) begin
					case (mode_in)
						plfg_pkg::MODE_SET:
							state_nxt = (immediate && attached_q) ? plfg_pkg::S_MAP
								: plfg_pkg::S_DONE;
						plfg_pkg::MODE_TICK:
							if (fading)
								state_nxt = reached ? plfg_pkg::S_MAP : plfg_pkg::S_CALC;
							else
								state_nxt = plfg_pkg::S_DONE;
						default: state_nxt = plfg_pkg::S_DONE;
					endcase
				end
			end
			plfg_pkg::S_CALC: begin
				if (md_done)
					state_nxt = (md_next != now_q) ? plfg_pkg::S_MAP : plfg_pkg::S_DONE;
			end
			plfg_pkg::S_MAP:  state_nxt = plfg_pkg::S_DONE;
			plfg_pkg::S_DONE: if (out_free) state_nxt = plfg_pkg::S_IDLE;
			default:          state_nxt = plfg_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plfg_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q     <= '0;
			gam_en_q   <= 1'b0;
			attached_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				plfg_pkg::REG_FADE_TIME: fade_q     <= cfg_data[plfg_pkg::TIME_BITS-1:0];
				plfg_pkg::REG_GAMMA_EN:  gam_en_q   <= cfg_data[0];
				plfg_pkg::REG_ATTACHED:  attached_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			goal_q     <= '0;
			origin_q   <= '0;
			ticks_q    <= '0;
			wrote_q    <= 1'b0;
			duty_src_q <= '0;
			gvalid_q   <= '0;
		end else begin
			case (state_q)
				plfg_pkg::S_IDLE: begin
					if (acc_in) begin
						wrote_q <= 1'b0;
						case (mode_in)
							plfg_pkg::MODE_SET: begin
								goal_q <= level_value;
								if (immediate) begin
									now_q      <= level_value;
									duty_src_q <= level_value;
									wrote_q    <= attached_q;
								end else begin
									origin_q <= now_q;
									ticks_q  <= '0;
								end
							end
							plfg_pkg::MODE_TICK: begin
								ticks_q <= tick_next;
								if (fading && reached) begin
									now_q      <= goal_q;
									duty_src_q <= goal_q;
									wrote_q    <= 1'b1;
								end
							end
							plfg_pkg::MODE_GAMMA: gvalid_q[table_index] <= 1'b1;
							default: ;
						endcase
					end
				end
				plfg_pkg::S_CALC: begin
					if (md_done && md_next != now_q) begin
						now_q      <= md_next;
						duty_src_q <= md_next;
						wrote_q    <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && mode_in == plfg_pkg::MODE_GAMMA)
			gamma_mem[table_index] <= level_value;
	end

	always_ff @(posedge clk) begin
		if (state_q == plfg_pkg::S_MAP)
			grd_q <= gamma_mem[duty_src_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grd_valid_q <= 1'b0;
		end else if (state_q == plfg_pkg::S_MAP) begin
			grd_valid_q <= gvalid_q[duty_src_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == plfg_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == plfg_pkg::S_DONE && out_free) begin
			out_write_q <= wrote_q;
			out_duty_q  <= wrote_q ? mapped : 8'd0;
			out_cur_q   <= now_q;
			out_tgt_q   <= goal_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign duty_write    = out_write_q;
	assign duty          = out_duty_q;
	assign current_level = out_cur_q;
	assign target_level  = out_tgt_q;

endmodule

`default_nettype wire

// ===== hdl/plfg_muldiv.sv =====
// ----------------------------------------------------------------------------
// plfg_muldiv: bit-serial multiply then divide
// Forms mag * mult one multiplier bit per cycle, then divides the product by
// the divisor with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plfg_muldiv (
	input  wire                              clk,
	input  wire                              arst_n,
	input  plfg_pkg::md_req_t                req,
	output logic                             done,
	output logic [plfg_pkg::LEVEL_BITS-1:0]  quot
);

	plfg_pkg::md_phase_t                  phase_q;
	plfg_pkg::md_phase_t                  phase_nxt;
	logic [plfg_pkg::CNT_BITS-1:0]        cnt_q;
	logic [plfg_pkg::PROD_BITS-1:0]       mcand_q;
	logic [plfg_pkg::TIME_BITS-1:0]       mplier_q;
	logic [plfg_pkg::PROD_BITS-1:0]       acc_q;
	logic [plfg_pkg::TIME_BITS-1:0]       rem_q;
	logic [plfg_pkg::TIME_BITS-1:0]       dvsr_q;
	logic                                 done_q;
	logic [plfg_pkg::TIME_BITS:0]         trial;
	logic                                 fits;

	assign trial = {rem_q, acc_q[plfg_pkg::PROD_BITS-1]};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			plfg_pkg::MD_IDLE: if (req.start) phase_nxt = plfg_pkg::MD_MUL;
			plfg_pkg::MD_MUL:  if (cnt_q == '0) phase_nxt = plfg_pkg::MD_DIV;
			plfg_pkg::MD_DIV:  if (cnt_q == '0) phase_nxt = plfg_pkg::MD_IDLE;
			default:           phase_nxt = plfg_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= plfg_pkg::MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_nxt;
			done_q  <= 1'b0;
			case (phase_q)
				plfg_pkg::MD_IDLE: begin
					cnt_q <= plfg_pkg::CNT_BITS'(plfg_pkg::TIME_BITS - 1);
				end
				plfg_pkg::MD_MUL: begin
					if (cnt_q == '0)
						cnt_q <= plfg_pkg::CNT_BITS'(plfg_pkg::PROD_BITS - 1);
					else
						cnt_q <= cnt_q - 1'b1;
				end
				plfg_pkg::MD_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						done_q <= 1'b1;
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			plfg_pkg::MD_IDLE: begin
				if (req.start) begin
					mcand_q  <= plfg_pkg::PROD_BITS'(req.mag);
					mplier_q <= req.mult;
					dvsr_q   <= req.divisor;
					acc_q    <= '0;
					rem_q    <= '0;
				end
			end
			plfg_pkg::MD_MUL: begin
				if (mplier_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[plfg_pkg::PROD_BITS-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[plfg_pkg::TIME_BITS-1:1]};
			end
			plfg_pkg::MD_DIV: begin
				if (fits)
					rem_q <= plfg_pkg::TIME_BITS'(trial - {1'b0, dvsr_q});
				else
					rem_q <= trial[plfg_pkg::TIME_BITS-1:0];
				acc_q <= {acc_q[plfg_pkg::PROD_BITS-2:0], fits};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = acc_q[plfg_pkg::LEVEL_BITS-1:0];

endmodule

`default_nettype wire
